// File: hdl/hts_pkg.sv
// Shared types and constants for the table-search Huffman decoder.
`default_nettype none

package hts_pkg;

  // Fixed field widths of the request and response items
  localparam int LEN_W       = 6;
  localparam int CODE_W      = 32;
  localparam int SYM_FIELD_W = 8;
  localparam int MSG_W       = 24;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_NUM_SYMBOLS  = 256;
  localparam int DEF_COUNT_BITS   = 24;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_BIT   = 2'd3
  } req_kind_t;

  // Response status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    req_kind_t                req_type;
    logic [SYM_FIELD_W-1:0]   entry_symbol;
    logic [LEN_W-1:0]         entry_length;
    logic [CODE_W-1:0]        entry_code;
    logic [MSG_W-1:0]         message_length;
    logic                     code_bit;
  } req_t;

  typedef struct packed {
    logic                     status;
    logic [SYM_FIELD_W-1:0]   out_symbol;
    logic                     message_done;
  } rsp_t;

  // One codebook entry as stored in the table
  typedef struct packed {
    logic [LEN_W-1:0]         len;
    logic [CODE_W-1:0]        code;
  } entry_t;

  // Accumulated outcome of one table scan
  typedef struct packed {
    logic                     hit;
    logic                     longer;
    logic [SYM_FIELD_W-1:0]   idx;
  } match_t;

endpackage

`default_nettype wire

// File: hdl/hts_table.sv
// Codebook entry memory with per-entry valid bits and a registered read port.
`default_nettype none

module hts_table
  import hts_pkg::*;
#(
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  localparam int SYM_W = $clog2(NUM_SYMBOLS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clr,
  input  wire logic             wr_en,
  input  wire logic [SYM_W-1:0] wr_addr,
  input  wire entry_t           wr_entry,
  input  wire logic [SYM_W-1:0] rd_addr,
  output entry_t                rd_entry
);

  entry_t                 mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld;
  entry_t                 rd_q;
  logic                   rd_vld;

  // Entry storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits: a cleared entry reads as unused
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (clr) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_entry.len  = rd_vld ? rd_q.len : '0;
  assign rd_entry.code = rd_q.code;

endmodule

`default_nettype wire

// File: hdl/hts_match.sv
// Shared compare unit: checks one table entry per cycle, while enabled, against the running word.
`default_nettype none

module hts_match
  import hts_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
  localparam int SYM_W = $clog2(NUM_SYMBOLS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    en,
  input  wire entry_t                  ent,
  input  wire logic [SYM_W-1:0]        idx,
  input  wire logic [MAX_CODE_LEN-1:0] pcode,
  input  wire logic [LEN_W-1:0]        plen,
  output match_t                       result
);

  localparam int CMP_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic is_longer;
  logic is_hit;

  // Length and code compare for the entry now on the read port
  always_comb begin
    is_longer = ent.len > plen;
    is_hit    = (ent.len == plen) && (CMP_W'(ent.code) == CMP_W'(pcode));
  end

  // Accumulate; the first hit freezes the result so the lowest symbol wins
  always_ff @(posedge clk) begin
    if (rst || start) begin
      result <= '0;
    end else if (en && !result.hit) begin
      if (is_longer) begin
        result.longer <= 1'b1;
      end else if (is_hit) begin
        result.hit <= 1'b1;
        result.idx <= SYM_FIELD_W'(idx);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/huffman_table_search_decoder.sv
// Top level: request sequencer, running code word and response register.
// Clear-table, load-entry and start-message requests are handled in the idle
// state, as is a coded bit that arrives while no message is being decoded. A
// coded bit during a message starts a scan: the sequencer walks the codebook
// memory one entry per cycle through its single registered read port into one
// shared compare unit, and stops early at the first matching entry. The
// response register lets the next request in while a result waits; a scan that
// finishes while a result is still untaken holds until it leaves. Per-entry
// valid bits are cleared at once by reset or a clear request, so no clearing
// pass is needed.
`default_nettype none

module huffman_table_search_decoder
  import hts_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp_data
);

  localparam int SYM_W = $clog2(NUM_SYMBOLS);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t                  state;
  logic [SYM_W-1:0]        cnt;
  logic                    d_vld;
  logic [SYM_W-1:0]        d_idx;
  logic [MAX_CODE_LEN-1:0] partial_code;
  logic [LEN_W-1:0]        partial_length;
  logic [COUNT_BITS-1:0]   bytes_left;
  logic                    active;

  logic                    accept;
  logic                    tbl_wr_en;
  logic                    tbl_clr;
  entry_t                  tbl_wr_entry;
  entry_t                  tbl_rd_entry;
  logic                    start_scan;
  logic                    cnt_last;
  logic                    out_free;
  logic                    rsp_load;
  logic [COUNT_BITS-1:0]   bytes_dec;
  logic [COUNT_BITS-1:0]   count_in;
  match_t                  match;

  // Request decode
  assign req_ready  = (state == IDLE);
  assign accept     = req_valid && req_ready;
  assign tbl_clr    = accept && (req_data.req_type == REQ_CLEAR);
  assign tbl_wr_en  = accept && (req_data.req_type == REQ_LOAD) &&
                      (int'(req_data.entry_symbol) < NUM_SYMBOLS);
  assign start_scan = accept && (req_data.req_type == REQ_BIT) && active;

  // Over-long codes are stored as unused
  assign tbl_wr_entry.len  = (int'(req_data.entry_length) > MAX_CODE_LEN) ?
                             '0 : req_data.entry_length;
  assign tbl_wr_entry.code = req_data.entry_code;

  assign cnt_last  = (cnt == SYM_W'(NUM_SYMBOLS - 1));
  assign out_free  = !rsp_valid || rsp_ready;
  assign bytes_dec = bytes_left - COUNT_BITS'(1);
  assign count_in  = COUNT_BITS'(req_data.message_length);

  // A result is loaded when a finished scan hit or found nothing longer
  assign rsp_load  = (state == FINISH) && out_free && (match.hit || !match.longer);

  hts_table #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .clr      (tbl_clr),
    .wr_en    (tbl_wr_en),
    .wr_addr  (req_data.entry_symbol[SYM_W-1:0]),
    .wr_entry (tbl_wr_entry),
    .rd_addr  (cnt),
    .rd_entry (tbl_rd_entry)
  );

  hts_match #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_match (
    .clk    (clk),
    .rst    (rst),
    .start  (start_scan),
    .en     (d_vld),
    .ent    (tbl_rd_entry),
    .idx    (d_idx),
    .pcode  (partial_code),
    .plen   (partial_length),
    .result (match)
  );

  // Sequencer, decode state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      cnt            <= '0;
      d_vld          <= 1'b0;
      partial_code   <= '0;
      partial_length <= '0;
      bytes_left     <= '0;
      active         <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      // read port is registered: data arrives in the cycle after its address
      d_vld <= (state == SCAN);
      d_idx <= cnt;

      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            case (req_data.req_type)
              REQ_START: begin
                partial_code   <= '0;
                partial_length <= '0;
                bytes_left     <= count_in;
                active         <= (count_in != '0);
              end
              REQ_BIT: begin
                if (active) begin
                  partial_code   <= (partial_code << 1) |
                                    MAX_CODE_LEN'(req_data.code_bit);
                  partial_length <= partial_length + LEN_W'(1);
                  cnt            <= '0;
                  state          <= SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        SCAN: begin
          if (match.hit) begin
            state <= FINISH;
          end else if (cnt_last) begin
            state <= DRAIN;
          end else begin
            cnt <= cnt + SYM_W'(1);
          end
        end
        DRAIN: begin
          // last entry is compared at this edge
          state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
            if (match.hit) begin
              rsp_valid             <= 1'b1;
              rsp_data.status       <= STATUS_OK;
              rsp_data.out_symbol   <= match.idx;
              rsp_data.message_done <= (bytes_dec == '0);
              bytes_left            <= bytes_dec;
              partial_code          <= '0;
              partial_length        <= '0;
              if (bytes_dec == '0) begin
                active <= 1'b0;
              end
            end else if (!match.longer) begin
              rsp_valid             <= 1'b1;
              rsp_data.status       <= STATUS_INVALID;
              rsp_data.out_symbol   <= '0;
              rsp_data.message_done <= 1'b0;
              partial_code          <= '0;
              partial_length        <= '0;
              active                <= 1'b0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A new result is only loaded on the way out of a scan
  a_rsp_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> (state == IDLE) && ($past(state) == FINISH))
    else $error("response raised outside scan completion");

  // Scans only run inside a message with a nonempty running word
  a_scan_active: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> active && (partial_length != '0))
    else $error("scan without active message");

  // Running word never grows beyond the longest allowed code
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    int'(partial_length) <= MAX_CODE_LEN)
    else $error("running word too long");

  // A bit outside a message changes nothing
  a_idle_bit: assert property (@(posedge clk) disable iff (rst)
    accept && (req_data.req_type == REQ_BIT) && !active |=>
      (state == IDLE) && $stable(partial_length) && $stable(bytes_left))
    else $error("inactive bit altered decode state");

endmodule

`default_nettype wire
